// ===== hdl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the max-heap priority queue.
// Used by max_heap_priority_queue_core, mhpq_result_checker and the testbench; depends on nothing else.
package mhpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 7;

  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OCC_W-1:0]    occ_t;

  // Operation codes on the func field.
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_DEL_MAX = 1'b1;

  // Result status codes.
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

endpackage

// ===== hdl/mhpq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the heap array for the priority queue.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/max_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Binary max-heap priority queue of signed 32-bit values, top level.
// Depends on mhpq_pkg and mhpq_ram.
//
//   Channel | Ports                                                          | Direction
//   --------+----------------------------------------------------------------+------------
//   input   | in_valid, in_stall, in_func, in_value                          | into core
//   result  | out_valid, out_stall, out_max_value, out_status, out_occupancy | out of core
//
// Sequencing: one item at a time; each sift level needs one or two reads of the heap RAM, which
// has a single read port, and a compare.
// Reset (synchronous, rst_n low) empties the queue; RAM entries at or above the fill count
// are never read, so the RAM is not cleared.
// Stalls: a stalled result waits in the output register; the next item is still accepted and
// processed, and only its hand-off to the output register waits.
module max_heap_priority_queue_core #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic signed [31:0]   in_value,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_max_value,
  output logic [1:0]           out_status,
  output logic [6:0]           out_occupancy
);

  // Address width of the heap array and width of the fill count (which can hold CAPACITY).
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;  // wide enough for a right child index of the last node

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE    = 4'd0;  // waiting for an item
  localparam logic [3:0] ST_SU_RD   = 4'd1;  // sift-up: read parent or finish at the root
  localparam logic [3:0] ST_SU_CMP  = 4'd2;  // sift-up: compare with parent
  localparam logic [3:0] ST_DL_ROOT = 4'd3;  // delete: root arrives, read last entry
  localparam logic [3:0] ST_DL_LAST = 4'd4;  // delete: last entry arrives
  localparam logic [3:0] ST_SD_RDL  = 4'd5;  // sift-down: read left child or finish
  localparam logic [3:0] ST_SD_RDR  = 4'd6;  // sift-down: left arrives, read right child
  localparam logic [3:0] ST_SD_SEL  = 4'd7;  // sift-down: pick the larger child
  localparam logic [3:0] ST_SD_CMP  = 4'd8;  // sift-down: compare moving value with child
  localparam logic [3:0] ST_DONE    = 4'd9;  // hand the result to the output register

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         ci_r, ci_nxt;
  mhpq_pkg::data_t       v_r, v_nxt;
  mhpq_pkg::data_t       cl_r, cl_nxt;
  logic                  hasr_r, hasr_nxt;
  mhpq_pkg::data_t       res_max_r, res_max_nxt;
  mhpq_pkg::status_t     res_stat_r, res_stat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  mhpq_pkg::data_t       out_max_r, out_max_nxt;
  mhpq_pkg::status_t     out_stat_r, out_stat_nxt;
  mhpq_pkg::occ_t        out_occ_r, out_occ_nxt;

  // Heap RAM port signals.
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  mhpq_pkg::data_t       ram_wdata, ram_rdata;

  // Shared signed comparator: cmp_lt = (cmp_a < cmp_b).
  mhpq_pkg::data_t       cmp_a, cmp_b;
  logic                  cmp_lt;

  // Index arithmetic around the current position.
  logic [AW-1:0]         pos_m1;
  logic [AW-1:0]         parent_idx;
  logic [IW-1:0]         left_idx, right_idx, cnt_ext;
  logic [CW+mhpq_pkg::OCC_W-1:0] occ_ext;
  logic                  in_acc, out_free;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_free   = !out_valid_r || !out_stall;

  assign pos_m1     = pos_r - AW'(1);
  assign parent_idx = pos_m1 >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign cnt_ext    = IW'(cnt_r);
  // Occupancy is reported modulo 2**7, as the field is only 7 bits wide.
  assign occ_ext    = {{mhpq_pkg::OCC_W{1'b0}}, cnt_r};

  // Operand selection for the one comparator; each compare state uses it once.
  always_comb begin
    cmp_a = ram_rdata;
    cmp_b = v_r;
    unique case (state_r)
      ST_SD_SEL: begin
        cmp_a = cl_r;
        cmp_b = ram_rdata;
      end
      ST_SD_CMP: begin
        cmp_a = v_r;
        cmp_b = cl_r;
      end
      default: begin
        cmp_a = ram_rdata;
        cmp_b = v_r;
      end
    endcase
  end

  assign cmp_lt = ($signed(cmp_a) < $signed(cmp_b));

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    ci_nxt       = ci_r;
    v_nxt        = v_r;
    cl_nxt       = cl_r;
    hasr_nxt     = hasr_r;
    res_max_nxt  = res_max_r;
    res_stat_nxt = res_stat_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = v_r;
    ram_re       = 1'b0;
    ram_raddr    = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_max_nxt  = '0;
          res_stat_nxt = mhpq_pkg::STAT_OK;
          if (in_func == mhpq_pkg::FUNC_INSERT) begin
            if (cnt_r == CAP_CNT) begin
              res_stat_nxt = mhpq_pkg::STAT_FULL;
              state_nxt    = ST_DONE;
            end else begin
              // The new value starts at the first free slot and is written once it settles.
              v_nxt     = in_value;
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = ST_SU_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_stat_nxt = mhpq_pkg::STAT_EMPTY;
              state_nxt    = ST_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = ST_DL_ROOT;
            end
          end
        end
      end

      ST_SU_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
          state_nxt = ST_SU_CMP;
        end
      end

      ST_SU_CMP: begin
        // The parent moves down only while it is strictly smaller than the new value.
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          pos_nxt   = parent_idx;
          state_nxt = ST_SU_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DL_ROOT: begin
        res_max_nxt = ram_rdata;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          // The entry at the old end becomes the new root candidate.
          ram_re    = 1'b1;
          ram_raddr = cnt_r[AW-1:0];
          state_nxt = ST_DL_LAST;
        end
      end

      ST_DL_LAST: begin
        v_nxt     = ram_rdata;
        pos_nxt   = '0;
        state_nxt = ST_SD_RDL;
      end

      ST_SD_RDL: begin
        if (left_idx >= cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = left_idx[AW-1:0];
          ci_nxt    = left_idx[AW-1:0];
          state_nxt = ST_SD_RDR;
        end
      end

      ST_SD_RDR: begin
        cl_nxt = ram_rdata;
        if (right_idx < cnt_ext) begin
          ram_re    = 1'b1;
          ram_raddr = right_idx[AW-1:0];
          hasr_nxt  = 1'b1;
          state_nxt = ST_SD_SEL;
        end else begin
          hasr_nxt  = 1'b0;
          state_nxt = ST_SD_CMP;
        end
      end

      ST_SD_SEL: begin
        // On a tie the left child is kept.
        if (hasr_r && cmp_lt) begin
          cl_nxt = ram_rdata;
          ci_nxt = right_idx[AW-1:0];
        end
        state_nxt = ST_SD_CMP;
      end

      ST_SD_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = cl_r;
          pos_nxt   = ci_r;
          state_nxt = ST_SD_RDL;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished operation, cleared when the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_max_nxt   = out_max_r;
    out_stat_nxt  = out_stat_r;
    out_occ_nxt   = out_occ_r;
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_max_nxt   = res_max_r;
      out_stat_nxt  = res_stat_r;
      out_occ_nxt   = occ_ext[mhpq_pkg::OCC_W-1:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    ci_r       <= ci_nxt;
    v_r        <= v_nxt;
    cl_r       <= cl_nxt;
    hasr_r     <= hasr_nxt;
    res_max_r  <= res_max_nxt;
    res_stat_r <= res_stat_nxt;
    out_max_r  <= out_max_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  mhpq_ram #(
    .WIDTH (mhpq_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_max_value = $signed(out_max_r);
  assign out_status    = out_stat_r;
  assign out_occupancy = out_occ_r;

  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("heap fill count above capacity");

  // Every accepted item takes the core out of the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("core idle right after accepting an item");

  // Reads stay inside the filled part of the heap (the last-entry read sits at the new count).
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && (state_r != ST_DL_ROOT)) |-> (CW'(ram_raddr) < cnt_r))
    else $error("heap read beyond the filled entries");

  // A refused insert only happens on a full heap.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && (res_stat_r == mhpq_pkg::STAT_FULL)) |-> (cnt_r == CAP_CNT))
    else $error("full status with room left");

  // Failed operations always return zero as the value.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && (res_stat_r != mhpq_pkg::STAT_OK)) |-> (res_max_r == '0))
    else $error("nonzero value on a failed operation");

endmodule

// ===== verif/mhpq_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for max_heap_priority_queue_core: mirrors the heap and compares each result.
// Depends on mhpq_pkg for the field types, operation codes and status codes.
module mhpq_result_checker #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_max_value,
  input  logic [1:0]         out_status,
  input  logic [6:0]         out_occupancy,
  output int                 mismatch_count,
  output int                 results_pending
);

  typedef struct packed {
    mhpq_pkg::data_t   max_value;
    mhpq_pkg::status_t status;
    mhpq_pkg::occ_t    occupancy;
  } heap_result_t;

  logic signed [mhpq_pkg::DATA_W-1:0] heap_vals [CAPACITY];
  int                                 heap_fill = 0;
  heap_result_t                       expected_results [$];

  // Applies one operation to the mirrored heap and returns the result it must produce.
  function automatic heap_result_t apply_heap_op(input logic op,
                                                 input logic signed [mhpq_pkg::DATA_W-1:0] value);
    heap_result_t                       res;
    logic signed [mhpq_pkg::DATA_W-1:0] moving;
    int                                 pos;
    int                                 parent;
    int                                 child;
    res = '{max_value: '0, status: mhpq_pkg::STAT_OK, occupancy: '0};
    if (op == mhpq_pkg::FUNC_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        res.status = mhpq_pkg::STAT_FULL;
      end else begin
        // Sift up: pass a parent only while strictly greater than it.
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_vals[parent] < value) begin
            heap_vals[pos] = heap_vals[parent];
            pos = parent;
          end else begin
            break;
          end
        end
        heap_vals[pos] = value;
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = mhpq_pkg::STAT_EMPTY;
      end else begin
        res.max_value = heap_vals[0];
        heap_fill--;
        moving = heap_vals[heap_fill];
        // Sift down against the larger child; the left child wins a tie.
        pos = 0;
        while (2 * pos + 1 < heap_fill) begin
          child = 2 * pos + 1;
          if (child + 1 < heap_fill && heap_vals[child] < heap_vals[child + 1]) child++;
          if (moving < heap_vals[child]) begin
            heap_vals[pos] = heap_vals[child];
            pos = child;
          end else begin
            break;
          end
        end
        if (heap_fill > 0) heap_vals[pos] = moving;
      end
    end
    res.occupancy = mhpq_pkg::occ_t'(heap_fill);
    return res;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      heap_fill = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_heap_op(in_func, in_value));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, max_value %0d status %0d occupancy %0d",
                   $time, out_max_value, out_status, out_occupancy);
        end else begin
          want = expected_results.pop_front();
          if (out_max_value !== want.max_value) begin
            mismatch_count++;
            $display("%0t: max_value mismatch, expected %0d, actual %0d",
                     $time, $signed(want.max_value), out_max_value);
          end
          if (out_status !== want.status) begin
            mismatch_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_occupancy !== want.occupancy) begin
            mismatch_count++;
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occupancy, out_occupancy);
          end
        end
      end
    end
    results_pending = expected_results.size();
  end

endmodule

// ===== verif/max_heap_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for max_heap_priority_queue_core: clock, reset, stimulus, idling and verdict.
// Depends on mhpq_pkg, the core itself and mhpq_result_checker.
module max_heap_priority_queue_core_tb;

  localparam int HEAP_DEPTH     = mhpq_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1125;
  // The last items run with neither input gaps nor result stalls.
  localparam int STEADY_TAIL    = 150;
  // Wait after the last result; a full delete-max at the default depth fits well within it.
  localparam int DRAIN_CYCLES   = 80;
  // Longest correct quiet stretch is a gap, a full delete-max and a stall, well under this.
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = mhpq_pkg::FUNC_INSERT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_max_value;
  logic [1:0]         out_status;
  logic [6:0]         out_occupancy;

  int mismatch_count;
  int results_pending;
  // Chance in percent that an item is preceded by an input gap, or that a result stall
  // burst begins on a given cycle. Zero gives stretches that run at full rate.
  int idle_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  max_heap_priority_queue_core #(.CAPACITY(HEAP_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_max_value(out_max_value),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  mhpq_result_checker #(.CAPACITY(HEAP_DEPTH)) u_result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_max_value  (out_max_value),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Presents one item and returns at the edge where the core takes it. Valid is held high
  // between back-to-back items, so it is only lowered when a gap is actually inserted.
  task automatic send_item(input logic op, input logic [31:0] value);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= op;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Values lean toward the signed extremes and a narrow band around zero, so that equal
  // keys, and with them the tie rules of both sifts, come up often.
  function automatic logic [31:0] pick_value();
    logic [31:0] val;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    val = 32'($urandom_range(0, 8)) - 32'd4;
      default: val = $urandom;
    endcase
    return val;
  endfunction

  // Result stalls come in bursts, each begun at the rate the current phase allows.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: a run in which nothing crosses either channel for too long is a failure.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** max_heap_priority_queue_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int phase_len;
    int insert_pct;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A delete-max on the empty queue comes first, then the signed extremes,
    // zero, minus one and a run of equal keys, and enough deletes to drain the heap and hit
    // the empty case once more. The value carried by a delete-max must be ignored.
    send_item(mhpq_pkg::FUNC_DEL_MAX, 32'h0000_0000);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h0000_0000);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h7FFF_FFFF);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h8000_0000);
    send_item(mhpq_pkg::FUNC_INSERT,  32'hFFFF_FFFF);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h0000_0001);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h0000_0005);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h0000_0005);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h0000_0005);
    send_item(mhpq_pkg::FUNC_INSERT,  32'h8000_0000);
    send_item(mhpq_pkg::FUNC_DEL_MAX, 32'hFFFF_FFFF);
    repeat (10) send_item(mhpq_pkg::FUNC_DEL_MAX, 32'h7FFF_FFFF);

    // Random part. Phases cycle through filling, mixing, draining and mixing again, so the
    // queue repeatedly reaches full (refused inserts) and empty (refused deletes), and
    // most of the traffic walks deep heaps rather than the first few levels.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          insert_pct = 95;
          phase_len  = $urandom_range(90, 130);
        end
        2: begin
          insert_pct = 5;
          phase_len  = $urandom_range(90, 130);
        end
        default: begin
          insert_pct = 50;
          phase_len  = $urandom_range(20, 60);
        end
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 8;
        default: idle_pct = 30;
      endcase
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - STEADY_TAIL) idle_pct = 0;
        if ($urandom_range(1, 100) <= insert_pct) begin
          send_item(mhpq_pkg::FUNC_INSERT, pick_value());
        end else begin
          send_item(mhpq_pkg::FUNC_DEL_MAX, $urandom);
        end
        sent++;
      end
      phase++;
    end
    in_valid <= 1'b0;
    idle_pct = 0;

    // Let the checker register the last item, wait for every result, then give the core
    // time to show any result that nothing asked for.
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** max_heap_priority_queue_core: PASSED **");
    end else begin
      $display("** max_heap_priority_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
